/* hdl/cfd_pkg.sv */
// Shared types, constants and the byte-wise CRC-32 step for the command frame deframer.
// Used by every module of the deframer; depends on nothing else.
`default_nettype none

package cfd_pkg;

	localparam int unsigned HeaderBytes = 16;
	localparam int unsigned CrcBytes    = 4;
	localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;

	localparam logic [15:0] SyncWordReset = 16'h0000;
	localparam logic [31:0] CrcSeedReset  = 32'hEDB8_8320;

	localparam int unsigned AddrWidth = 3;

	localparam logic [0:0] REG_SYNC_WORD = 1'b0;
	localparam logic [0:0] REG_CRC_SEED  = 1'b1;

	localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
	localparam logic [1:0] KIND_FRAME_OK  = 2'd1;
	localparam logic [1:0] KIND_FRAME_BAD = 2'd2;

	typedef struct packed {
		logic [15:0] sync_word;
		logic [31:0] crc_seed;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic [15:0] command;
		logic [31:0] source_address;
		logic [15:0] fragment_no;
		logic [15:0] last_fragment_no;
		logic [15:0] frame_type;
		logic [15:0] payload_length;
	} result_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h000000, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* hdl/cfd_cfg_regs.sv */
// APB-style configuration registers of the deframer: sync word and CRC seed.
// Depends on cfd_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module cfd_cfg_regs import cfd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [AddrWidth-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready,
	output cfg_t                      cfg
);

	logic [15:0] sync_word_q;
	logic [31:0] crc_seed_q;
	logic        wr_en;
	logic [0:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[2:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q <= SyncWordReset;
			crc_seed_q  <= CrcSeedReset;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SYNC_WORD: sync_word_q <= pwdata[15:0];
				REG_CRC_SEED:  crc_seed_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SYNC_WORD: prdata = {16'h0000, sync_word_q};
			REG_CRC_SEED:  prdata = crc_seed_q;
			default:       prdata = 32'h0000_0000;
		endcase
	end

	assign cfg.sync_word = sync_word_q;
	assign cfg.crc_seed  = crc_seed_q;

endmodule

`default_nettype wire

/* hdl/cfd_parser.sv */
// Frame parser: sync hunt, header capture, payload CRC and frame verdict, one byte per cycle while accept is high.
// Depends on cfd_pkg for cfg_t, result_t, the kind codes and crc32_byte.
`default_nettype none

module cfd_parser import cfd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] data_byte,
	input  wire cfg_t       cfg,
	output logic            push,
	output result_t         res
);

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_CRC     = 2'd3;

	localparam logic [15:0] HdrLast = 16'(HeaderBytes - 1);
	localparam logic [15:0] CrcLast = 16'(CrcBytes - 1);

	logic [1:0]  phase_q, phase_d;
	logic [15:0] cnt_q, cnt_d;
	logic [7:0]  prev_q;
	logic [15:0] cmd_q, frag_q, last_frag_q, type_q, len_q;
	logic [31:0] addr_q, crc_q, rcv_q;

	logic [15:0] cnt_inc;
	logic [15:0] len_next;
	logic [31:0] rcv_next;
	logic [31:0] crc_next;

	assign cnt_inc  = cnt_q + 16'd1;
	assign len_next = {len_q[7:0], data_byte};
	assign rcv_next = {rcv_q[23:0], data_byte};
	assign crc_next = crc32_byte(crc_q, data_byte);

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		push    = 1'b0;
		res     = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (cnt_q != 16'd0 && {prev_q, data_byte} == cfg.sync_word) begin
					phase_d = PH_HEADER;
					cnt_d   = 16'd2;
				end else begin
					cnt_d = 16'd1;
				end
			end
			PH_HEADER: begin
				cnt_d = cnt_inc;
				if (cnt_q == HdrLast) begin
					cnt_d   = 16'd0;
					phase_d = (len_next == 16'd0) ? PH_CRC : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				cnt_d            = cnt_inc;
				push             = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = data_byte;
				if (cnt_inc >= len_q) begin
					cnt_d   = 16'd0;
					phase_d = PH_CRC;
				end
			end
			PH_CRC: begin
				cnt_d = cnt_inc;
				if (cnt_q == CrcLast) begin
					push                 = 1'b1;
					res.kind             = (rcv_next == 32'd0 || rcv_next == crc_q) ?
					                       KIND_FRAME_OK : KIND_FRAME_BAD;
					res.command          = cmd_q;
					res.source_address   = addr_q;
					res.fragment_no      = frag_q;
					res.last_fragment_no = last_frag_q;
					res.frame_type       = type_q;
					res.payload_length   = len_q;
					phase_d              = PH_HUNT;
					cnt_d                = 16'd0;
				end
			end
			default: ;
		endcase
		if (!accept) begin
			push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q   <= 16'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (phase_q == PH_HUNT) begin
				prev_q <= data_byte;
			end
			if (phase_q == PH_HEADER) begin
				if (cnt_q < 16'd4) begin
					cmd_q <= {cmd_q[7:0], data_byte};
				end else if (cnt_q < 16'd8) begin
					addr_q <= {addr_q[23:0], data_byte};
				end else if (cnt_q < 16'd10) begin
					frag_q <= {frag_q[7:0], data_byte};
				end else if (cnt_q < 16'd12) begin
					last_frag_q <= {last_frag_q[7:0], data_byte};
				end else if (cnt_q < 16'd14) begin
					type_q <= {type_q[7:0], data_byte};
				end else begin
					len_q <= len_next;
				end
				if (cnt_q == HdrLast) begin
					crc_q <= cfg.crc_seed;
					rcv_q <= 32'd0;
				end
			end
			if (phase_q == PH_PAYLOAD) begin
				crc_q <= crc_next;
			end
			if (phase_q == PH_CRC) begin
				rcv_q <= rcv_next;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/cfd_out_fifo.sv */
// Two-entry result queue that decouples the parser from the downstream stall.
// Depends on cfd_pkg for result_t.
`default_nettype none

module cfd_out_fifo import cfd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t din,
	input  wire logic    pop,
	output logic         full,
	output logic         nonempty,
	output result_t      dout
);

	result_t    mem_q [2];
	logic [0:0] wr_ptr_q;
	logic [0:0] rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign dout     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

/* hdl/command_frame_deframer_crc32.sv */
// Top level of the command frame deframer with payload CRC-32.
// Depends on cfd_pkg, cfd_cfg_regs, cfd_parser and cfd_out_fifo.
//
//   Channel   Handshake            Word
//   config    APB psel/penable     sync_word at 0x0, crc_seed at 0x4
//   input     in_valid/in_stall    data_byte
//   output    out_valid/out_stall  kind, payload_byte, header fields
//
// One byte is accepted per cycle while in_stall is low; the parser state and CRC step settle in that cycle.
// A result is registered in the result queue when its byte is accepted; out_valid shows the queue head.
// in_stall rises only when the two-entry result queue is full.
// Reset clears the parser to the sync hunt and the registers to their defaults.
`default_nettype none

module command_frame_deframer_crc32 import cfd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [AddrWidth-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           data_byte,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [1:0]           kind,
	output logic      [7:0]           payload_byte,
	output logic      [15:0]          command,
	output logic      [31:0]          source_address,
	output logic      [15:0]          fragment_no,
	output logic      [15:0]          last_fragment_no,
	output logic      [15:0]          frame_type,
	output logic      [15:0]          payload_length
);

	cfg_t    cfg;
	result_t res;
	result_t head;
	logic    accept;
	logic    push;
	logic    full;

	cfd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_stall = full;
	assign accept   = in_valid && !full;

	cfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.cfg       (cfg),
		.push      (push),
		.res       (res)
	);

	cfd_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (res),
		.pop      (out_valid && !out_stall),
		.full     (full),
		.nonempty (out_valid),
		.dout     (head)
	);

	assign kind             = head.kind;
	assign payload_byte     = head.payload_byte;
	assign command          = head.command;
	assign source_address   = head.source_address;
	assign fragment_no      = head.fragment_no;
	assign last_fragment_no = head.last_fragment_no;
	assign frame_type       = head.frame_type;
	assign payload_length   = head.payload_length;

endmodule

`default_nettype wire

/* hdl/cfd_checker.sv */
// Port-level checks for the command frame deframer, bound to the top level.
// Depends on cfd_pkg for the kind codes.
`default_nettype none

module cfd_checker import cfd_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        pready,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  kind,
	input wire logic [7:0]  payload_byte,
	input wire logic [15:0] command,
	input wire logic [31:0] source_address,
	input wire logic [15:0] payload_length
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(payload_byte))
		else $error("Stalled output word changed.");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind == KIND_PAYLOAD || kind == KIND_FRAME_OK || kind == KIND_FRAME_BAD)
		else $error("Output kind code is not defined.");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_PAYLOAD |->
			command == 16'd0 && source_address == 32'd0 && payload_length == 16'd0)
		else $error("Payload word carries header fields.");

	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_PAYLOAD |-> payload_byte == 8'd0)
		else $error("Frame end word carries a payload byte.");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("Configuration port inserted a wait state.");

endmodule

bind command_frame_deframer_crc32 cfd_checker u_cfd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.pready         (pready),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.kind           (kind),
	.payload_byte   (payload_byte),
	.command        (command),
	.source_address (source_address),
	.payload_length (payload_length)
);

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for command_frame_deframer_crc32: frames, noise and broken frames
// are streamed in while a local frame parser predicts every output word.
// Depends on cfd_pkg and the deframer RTL only.

module testbench import cfd_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HoldCycles = 300;
	localparam int StallLimit = 3000;

	typedef enum logic [1:0] {HUNT_SYNC, TAKE_HEADER, TAKE_PAYLOAD, TAKE_CRC} parse_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       typed;
		logic [1:0] kind;
		logic [7:0] payload;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel, penable, pwrite;
	logic [AddrWidth-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic [7:0]  data_byte, payload_byte;
	logic [1:0]  kind;
	logic [15:0] command, fragment_no, last_fragment_no, frame_type, payload_length;
	logic [31:0] source_address;

	logic [15:0]  sync_cfg = SyncWordReset;
	logic [31:0]  seed_cfg = CrcSeedReset;
	parse_phase_t st_phase = HUNT_SYNC;
	logic [15:0]  st_count = '0;
	logic [7:0]   st_prev = '0;
	logic [15:0]  hdr_cmd = '0, hdr_frag = '0, hdr_last = '0, hdr_type = '0, hdr_len = '0;
	logic [31:0]  hdr_addr = '0, crc_run = '0, crc_rx = '0;

	result_t    parsed_words[$];
	result_t    head_word;
	logic [7:0] stream_bytes[$];

	int in_idle_pct = 0;
	int stall_pct = 0;
	bit hold_request = 1'b0;
	int idle_cycles = 0;
	int errors = 0;
	int bytes_sent = 0;
	int settings = 1;
	int payload_seen = 0, frames_good = 0, frames_bad = 0;

	stim_row_t directed_rows [23] = '{
		'{8'h00, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'h5A, 1'b0, KIND_PAYLOAD, 8'h00},
		'{8'h00, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00},
		'{8'hFF, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'hFF, 1'b0, KIND_PAYLOAD, 8'h00},
		'{8'hFF, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'hFF, 1'b0, KIND_PAYLOAD, 8'h00},
		'{8'hFF, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'hFF, 1'b0, KIND_PAYLOAD, 8'h00},
		'{8'h00, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00},
		'{8'hFF, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'hFF, 1'b0, KIND_PAYLOAD, 8'h00},
		'{8'h00, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00},
		'{8'h00, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'h01, 1'b0, KIND_PAYLOAD, 8'h00},
		'{8'hFF, 1'b1, KIND_PAYLOAD, 8'hFF},
		'{8'h00, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00},
		'{8'h00, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'h00, 1'b1, KIND_FRAME_OK, 8'h00}
	};

	command_frame_deframer_crc32 DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .payload_byte(payload_byte), .command(command),
		.source_address(source_address), .fragment_no(fragment_no),
		.last_fragment_no(last_fragment_no), .frame_type(frame_type),
		.payload_length(payload_length)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] x;
		x = crc ^ {24'h0, b};
		repeat (8) x = (x >> 1) ^ (x[0] ? CrcPoly : 32'h0);
		return x;
	endfunction

	function automatic bit deframe_byte(input logic [7:0] b, output result_t word);
		word = '0;
		case (st_phase)
		HUNT_SYNC: begin
			if (st_count != 0 && {st_prev, b} == sync_cfg) begin
				st_phase = TAKE_HEADER;
				st_count = 16'd2;
			end else begin
				st_count = 16'd1;
			end
			st_prev = b;
			return 1'b0;
		end
		TAKE_HEADER: begin
			if (st_count < 4) hdr_cmd = {hdr_cmd[7:0], b};
			else if (st_count < 8) hdr_addr = {hdr_addr[23:0], b};
			else if (st_count < 10) hdr_frag = {hdr_frag[7:0], b};
			else if (st_count < 12) hdr_last = {hdr_last[7:0], b};
			else if (st_count < 14) hdr_type = {hdr_type[7:0], b};
			else hdr_len = {hdr_len[7:0], b};
			st_count++;
			if (st_count >= HeaderBytes) begin
				crc_run = seed_cfg;
				crc_rx = '0;
				st_count = '0;
				if (hdr_len == 0) st_phase = TAKE_CRC;
				else st_phase = TAKE_PAYLOAD;
			end
			return 1'b0;
		end
		TAKE_PAYLOAD: begin
			crc_run = crc_update(crc_run, b);
			st_count++;
			if (st_count >= hdr_len) begin
				st_count = '0;
				st_phase = TAKE_CRC;
			end
			word.kind = KIND_PAYLOAD;
			word.payload_byte = b;
			return 1'b1;
		end
		default: begin
			crc_rx = {crc_rx[23:0], b};
			st_count++;
			if (st_count < CrcBytes) return 1'b0;
			word.kind = (crc_rx == 0 || crc_rx == crc_run) ? KIND_FRAME_OK : KIND_FRAME_BAD;
			word.command = hdr_cmd;
			word.source_address = hdr_addr;
			word.fragment_no = hdr_frag;
			word.last_fragment_no = hdr_last;
			word.frame_type = hdr_type;
			word.payload_length = hdr_len;
			st_phase = HUNT_SYNC;
			st_count = '0;
			return 1'b1;
		end
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(7))
		0: return 32'h0;
		1: return 32'hFFFF_FFFF;
		default: return $urandom;
		endcase
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic typed, input logic [1:0] k,
			input logic [7:0] pay);
		result_t word;
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		bytes_sent++;
		if (deframe_byte(b, word)) begin
			if (typed) begin
				word.kind = k;
				word.payload_byte = pay;
			end
			parsed_words.push_back(word);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (parsed_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_register(input logic [0:0] idx, input logic [31:0] value);
		logic [31:0] mask;
		logic [31:0] readback;
		mask = (idx == REG_SYNC_WORD) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		readback = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_SYNC_WORD) sync_cfg = value[15:0];
		else seed_cfg = value;
		compare_field("prdata", value & mask, readback & mask);
	endtask

	task automatic run_traffic(input int count);
		int start;
		int pick;
		int variant;
		logic [15:0] len;
		logic [31:0] crc;
		logic [7:0] b;
		logic [127:0] hdr;
		start = bytes_sent;
		while (bytes_sent - start < count) begin
			stream_bytes.delete();
			pick = $urandom_range(99);
			if (pick < 85) begin
				if ($urandom_range(99) < 12) len = 16'd0;
				else if ($urandom_range(99) < 85) len = 16'($urandom_range(1, 6));
				else len = 16'($urandom_range(7, 24));
				hdr = {sync_cfg, 16'(pick_value()), pick_value(), 16'(pick_value()),
					16'(pick_value()), 16'(pick_value()), len};
				for (int i = 15; i >= 0; i--) stream_bytes.push_back(hdr[i*8 +: 8]);
				crc = seed_cfg;
				repeat (len) begin
					b = 8'($urandom);
					crc = crc_update(crc, b);
					stream_bytes.push_back(b);
				end
				variant = $urandom_range(99);
				if (variant < 15) crc = 32'h0;
				else if (variant < 35) crc = crc ^ (32'h1 << $urandom_range(31));
				else if (variant < 42) crc = $urandom;
				for (int i = 3; i >= 0; i--) stream_bytes.push_back(crc[i*8 +: 8]);
				if (variant >= 94)
					repeat ($urandom_range(1, stream_bytes.size() - 2)) stream_bytes.pop_back();
			end else if (pick < 92) begin
				stream_bytes.push_back(sync_cfg[15:8]);
				stream_bytes.push_back(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 5)) stream_bytes.push_back(8'($urandom));
			end
			foreach (stream_bytes[i])
				if (bytes_sent - start < count) send_byte(stream_bytes[i], 1'b0, KIND_PAYLOAD, 8'h00);
		end
	endtask

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				repeat (HoldCycles) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (parsed_words.size() == 0) begin
				$error("unexpected word: kind %0h, payload_byte %0h", kind, payload_byte);
				errors++;
			end else begin
				head_word = parsed_words.pop_front();
				compare_field("kind", head_word.kind, kind);
				compare_field("payload_byte", head_word.payload_byte, payload_byte);
				compare_field("command", head_word.command, command);
				compare_field("source_address", head_word.source_address, source_address);
				compare_field("fragment_no", head_word.fragment_no, fragment_no);
				compare_field("last_fragment_no", head_word.last_fragment_no, last_fragment_no);
				compare_field("frame_type", head_word.frame_type, frame_type);
				compare_field("payload_length", head_word.payload_length, payload_length);
				if (head_word.kind == KIND_PAYLOAD) payload_seen++;
				else if (head_word.kind == KIND_FRAME_OK) frames_good++;
				else frames_bad++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= StallLimit) begin
			$display("Watchdog expired after %0d cycles without a handshake.", idle_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [15:0] sync_values [6];
		logic [31:0] seed_values [6];
		sync_values = '{16'hFFFF, 16'h0000, 16'($urandom), 16'hEB90, 16'($urandom), 16'h7E7E};
		seed_values = '{32'h0, 32'hFFFF_FFFF, CrcSeedReset, $urandom, $urandom, 32'hFFFF_FFFF};
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		data_byte <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].kind,
				directed_rows[i].payload);

		for (int p = 0; p < 6; p++) begin
			drain();
			program_register(REG_SYNC_WORD, {16'h0, sync_values[p]});
			program_register(REG_CRC_SEED, seed_values[p]);
			settings++;
			case (p % 4)
			0: begin
				in_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				in_idle_pct = 83;
				stall_pct = 0;
			end
			2: begin
				in_idle_pct = 0;
				stall_pct = 83;
			end
			default: begin
				in_idle_pct = 14;
				stall_pct = 14;
			end
			endcase
			if (p == 0) hold_request = 1'b1;
			run_traffic(75);
		end

		in_valid <= 1'b0;
		while (parsed_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d bytes over %0d register settings; checked %0d payload words.",
			bytes_sent, settings, payload_seen);
		$display("Frame ends checked: %0d with good CRC, %0d with bad CRC.", frames_good, frames_bad);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
